// File: src/gbp_pkg.sv
// Shared types, constants and a helper function of the greedy best-position placer.
`timescale 1ns / 1ps

package gbp_pkg;

  // Default number of entries in each store.
  localparam int STORE_DEPTH_DEF = 1024;

  // Field widths.
  localparam int OP_W     = 2;
  localparam int POS_W    = 10;
  localparam int CHAR_W   = 32;
  localparam int GAIN_W   = 33;
  localparam int LEN_W    = 11;
  localparam int S_DATA_W = 48;
  localparam int M_DATA_W = 80;

  // Reset value of the search length register.
  localparam logic [LEN_W-1:0] ACT_LEN_RESET = 11'd1024;

  // Request kinds carried in the input tuser.
  typedef enum logic [OP_W-1:0] {
    OP_LOAD = 2'd0,
    OP_FEED = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } opcode_t;

  // Control that travels along the scoring pipeline with each entry.
  typedef struct packed {
    logic vld;
    logic first;
    logic last;
  } scan_ctl_t;

  // Absolute difference of two character codes.
  function automatic logic [CHAR_W-1:0] absdiff(logic [CHAR_W-1:0] a, logic [CHAR_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

// File: src/gbp_store.sv
// Template and result stores: two single-port-write memories with one shared read address.
`timescale 1ns / 1ps

module gbp_store #(
  parameter int STORE_DEPTH = gbp_pkg::STORE_DEPTH_DEF,
  parameter int AW          = $clog2(STORE_DEPTH)
) (
  input  logic                      clk,
  input  logic                      t_we,
  input  logic [AW-1:0]             t_waddr,
  input  logic [gbp_pkg::CHAR_W-1:0] t_wdata,
  input  logic                      r_we,
  input  logic [AW-1:0]             r_waddr,
  input  logic [gbp_pkg::CHAR_W-1:0] r_wdata,
  input  logic [AW-1:0]             raddr,
  output logic [gbp_pkg::CHAR_W-1:0] t_rdata,
  output logic [gbp_pkg::CHAR_W-1:0] r_rdata
);

  logic [gbp_pkg::CHAR_W-1:0] tmem [STORE_DEPTH];
  logic [gbp_pkg::CHAR_W-1:0] rmem [STORE_DEPTH];

  // Template memory with registered read.
  always_ff @(posedge clk) begin
    if (t_we) begin
      tmem[t_waddr] <= t_wdata;
    end
    t_rdata <= tmem[raddr];
  end

  // Result memory with registered read.
  always_ff @(posedge clk) begin
    if (r_we) begin
      rmem[r_waddr] <= r_wdata;
    end
    r_rdata <= rmem[raddr];
  end

endmodule

// File: src/gbp_scan.sv
// Scoring pipeline that ranks each scanned position and keeps the best one.
`timescale 1ns / 1ps

module gbp_scan #(
  parameter int STORE_DEPTH = gbp_pkg::STORE_DEPTH_DEF,
  parameter int AW          = $clog2(STORE_DEPTH)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  gbp_pkg::scan_ctl_t                ctl,
  input  logic [AW-1:0]                     idx,
  input  logic [gbp_pkg::CHAR_W-1:0]        chr,
  input  logic [gbp_pkg::CHAR_W-1:0]        t_rdata,
  input  logic [gbp_pkg::CHAR_W-1:0]        r_rdata,
  output logic                              done,
  output logic [AW-1:0]                     best_idx,
  output logic signed [gbp_pkg::GAIN_W-1:0] best_gain
);

  gbp_pkg::scan_ctl_t ctl_d, ctl1, ctl2;
  logic [AW-1:0] idx_d, idx1, idx2;
  logic [gbp_pkg::CHAR_W-1:0] away, near;
  logic signed [gbp_pkg::GAIN_W-1:0] score;

  // Align control with the memory read data.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_d <= '0;
      ctl1  <= '0;
      ctl2  <= '0;
      done  <= 1'b0;
    end else begin
      ctl_d <= ctl;
      ctl1  <= ctl_d;
      ctl2  <= ctl1;
      done  <= ctl2.vld && ctl2.last;
    end
  end

  // Distance stage, difference stage and best tracking.
  always_ff @(posedge clk) begin
    idx_d <= idx;
    idx1  <= idx_d;
    idx2  <= idx1;
    away  <= gbp_pkg::absdiff(t_rdata, r_rdata);
    near  <= gbp_pkg::absdiff(t_rdata, chr);
    score <= $signed({1'b0, away}) - $signed({1'b0, near});
    // The first position always seeds the search; later ones must be strictly better.
    if (ctl2.vld && (ctl2.first || (score > best_gain))) begin
      best_gain <= score;
      best_idx  <= idx2;
    end
  end

endmodule

// File: src/greedy_best_position_placer.sv
// Top level of the greedy best-position placer: sequencer, index reduction and output register.
// An unused opcode goes straight to the response; a load or a read first reduces the position; a
// feed scans the effective search length (one template and result read pair per cycle) and
// writes the winner back. One request is in work at a time; the next is accepted in the cycle after
// the result register is loaded, while that result may still wait for the receiver. Config writes
// are taken at all times. Reset: the result store is swept to zero, taking no request meanwhile.
`timescale 1ns / 1ps

module greedy_best_position_placer #(
  parameter int STORE_DEPTH = gbp_pkg::STORE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // Input request.
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [gbp_pkg::S_DATA_W-1:0]  s_tdata,  // position[9:0], char_code[41:10], zero pad
  input  logic [gbp_pkg::OP_W-1:0]      s_tuser,  // opcode[1:0]
  // Result.
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [gbp_pkg::M_DATA_W-1:0]  m_tdata,  // placed_index[9:0], best_gain[42:10],
                                                  // entry_value[74:43], zero pad
  // Search length register write.
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [gbp_pkg::LEN_W-1:0]     cfg_data
);

  localparam int AW     = $clog2(STORE_DEPTH);
  localparam int MODW   = $clog2(STORE_DEPTH + 1) + gbp_pkg::POS_W;
  localparam int MOD_SH = gbp_pkg::POS_W + $clog2(STORE_DEPTH);
  localparam int RECIPW = gbp_pkg::POS_W + 2;
  localparam int PRODW  = gbp_pkg::POS_W + RECIPW;
  localparam longint unsigned RECIP = ((64'd1 << MOD_SH) + 64'(STORE_DEPTH) - 64'd1)
                                      / 64'(STORE_DEPTH);
  localparam int PADW   = gbp_pkg::M_DATA_W - gbp_pkg::POS_W - gbp_pkg::GAIN_W
                          - gbp_pkg::CHAR_W;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_EXEC,
    ST_RDATA,
    ST_SCAN,
    ST_DRAIN,
    ST_RESP
  } state_t;

  state_t state;
  gbp_pkg::opcode_t op;
  logic [gbp_pkg::LEN_W-1:0]  active_length;
  logic [gbp_pkg::CHAR_W-1:0] chr;
  logic [gbp_pkg::POS_W-1:0]  rem;
  logic [gbp_pkg::POS_W-1:0]  quot;
  logic [gbp_pkg::POS_W-1:0]  quot_next;
  logic [PRODW-1:0]           quot_prod;
  logic [MODW-1:0]            quot_mul;
  logic [AW-1:0]              clr_addr;
  logic [AW-1:0]              scan_idx;
  logic [AW-1:0]              last_idx;
  logic [AW-1:0]              last_next;
  logic [gbp_pkg::POS_W-1:0]  res_index;
  logic signed [gbp_pkg::GAIN_W-1:0] res_gain;
  logic [gbp_pkg::CHAR_W-1:0] res_value;

  logic                       t_we, r_we;
  logic [AW-1:0]              t_waddr, r_waddr, raddr;
  logic [gbp_pkg::CHAR_W-1:0] r_wdata, t_rdata, r_rdata;
  gbp_pkg::scan_ctl_t         scan_ctl;
  logic                       scan_done;
  logic [AW-1:0]              best_idx;
  logic signed [gbp_pkg::GAIN_W-1:0] best_gain;

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  // Quotient of the incoming position by the store depth through a reciprocal multiply.
  assign quot_prod = PRODW'(s_tdata[gbp_pkg::POS_W-1:0]) * PRODW'(RECIP);
  assign quot_next = gbp_pkg::POS_W'(quot_prod >> MOD_SH);
  assign quot_mul  = MODW'(quot) * MODW'(STORE_DEPTH);

  // Last searched index: a zero length searches position 0, one beyond the depth stops at the last entry.
  always_comb begin
    if (active_length == '0) begin
      last_next = '0;
    end else if (32'(active_length) > 32'(STORE_DEPTH)) begin
      last_next = AW'(STORE_DEPTH - 1);
    end else begin
      last_next = AW'(active_length - 1'b1);
    end
  end

  // Store access control.
  always_comb begin
    t_we     = (state == ST_EXEC) && (op == gbp_pkg::OP_LOAD);
    t_waddr  = AW'(rem);
    r_we     = (state == ST_CLEAR) || ((state == ST_DRAIN) && scan_done);
    r_waddr  = (state == ST_CLEAR) ? clr_addr : best_idx;
    r_wdata  = (state == ST_CLEAR) ? '0 : chr;
    raddr    = (state == ST_SCAN) ? scan_idx : AW'(rem);
    scan_ctl.vld   = (state == ST_SCAN);
    scan_ctl.first = (scan_idx == '0);
    scan_ctl.last  = (scan_idx == last_idx);
  end

  // Sequencer with registered results.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr_addr      <= '0;
      m_tvalid      <= 1'b0;
      active_length <= gbp_pkg::ACT_LEN_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        active_length <= cfg_data;
      end
      // Output register: loaded from the response state, cleared once taken.
      if ((state == ST_RESP) && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(STORE_DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_tvalid) begin
            op        <= gbp_pkg::opcode_t'(s_tuser);
            rem       <= s_tdata[gbp_pkg::POS_W-1:0];
            quot      <= quot_next;
            chr       <= s_tdata[gbp_pkg::POS_W +: gbp_pkg::CHAR_W];
            res_index <= s_tdata[gbp_pkg::POS_W-1:0];
            res_gain  <= '0;
            res_value <= '0;
            scan_idx  <= '0;
            last_idx  <= last_next;
            unique case (gbp_pkg::opcode_t'(s_tuser))
              gbp_pkg::OP_FEED: state <= ST_SCAN;
              gbp_pkg::OP_LOAD,
              gbp_pkg::OP_READ: state <= ST_MOD;
              gbp_pkg::OP_NONE: state <= ST_RESP;
            endcase
          end
        end
        ST_MOD: begin
          // Subtract the quotient times the depth to reduce the position.
          rem   <= rem - gbp_pkg::POS_W'(quot_mul);
          state <= ST_EXEC;
        end
        ST_EXEC: begin
          state <= (op == gbp_pkg::OP_READ) ? ST_RDATA : ST_RESP;
        end
        ST_RDATA: begin
          res_value <= r_rdata;
          state     <= ST_RESP;
        end
        ST_SCAN: begin
          scan_idx <= scan_idx + 1'b1;
          if (scan_idx == last_idx) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          // The winning entry is written back in this same cycle.
          if (scan_done) begin
            res_index <= gbp_pkg::POS_W'(best_idx);
            res_gain  <= best_gain;
            res_value <= chr;
            state     <= ST_RESP;
          end
        end
        ST_RESP: begin
          if (!m_tvalid || m_tready) begin
            m_tdata <= {PADW'(0), res_value, res_gain, res_index};
            state   <= ST_IDLE;
          end
        end
      endcase
    end
  end

  gbp_store #(
    .STORE_DEPTH(STORE_DEPTH),
    .AW         (AW)
  ) u_store (
    .clk    (clk),
    .t_we   (t_we),
    .t_waddr(t_waddr),
    .t_wdata(chr),
    .r_we   (r_we),
    .r_waddr(r_waddr),
    .r_wdata(r_wdata),
    .raddr  (raddr),
    .t_rdata(t_rdata),
    .r_rdata(r_rdata)
  );

  gbp_scan #(
    .STORE_DEPTH(STORE_DEPTH),
    .AW         (AW)
  ) u_scan (
    .clk      (clk),
    .rst      (rst),
    .ctl      (scan_ctl),
    .idx      (scan_idx),
    .chr      (chr),
    .t_rdata  (t_rdata),
    .r_rdata  (r_rdata),
    .done     (scan_done),
    .best_idx (best_idx),
    .best_gain(best_gain)
  );

  // A finished scan is only reported while the sequencer waits for it.
  a_done_in_drain: assert property (@(posedge clk) disable iff (rst)
    scan_done |-> (state == ST_DRAIN))
    else $error("scan finished outside the drain state");

  // The chosen position lies inside the searched range.
  a_best_in_range: assert property (@(posedge clk) disable iff (rst)
    scan_done |-> (best_idx <= last_idx))
    else $error("chosen position beyond the search length");

  // The reduced index addresses an existing entry.
  a_index_reduced: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EXEC) |-> (32'(rem) < 32'(STORE_DEPTH)))
    else $error("index not reduced below the store depth");

  // Only one request is in work at a time.
  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second request accepted while one is in work");

endmodule
